// ===== design/hrod_pkg.sv =====
// Shared types and constants for the heart-rate outlier detector.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package hrod_pkg;

  // Sliding window depth.
  localparam int WINDOW = 50;

  // Field widths of the item and result.
  localparam int HR_W       = 8;
  localparam int OX_W       = 7;
  localparam int K_W        = 4;
  localparam int CNT_OUT_W  = 6;
  localparam int SUM_OUT_W  = 14;
  localparam int SQ_OUT_W   = 22;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_BITS    = HR_W + OX_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 + CNT_OUT_W + SUM_OUT_W + SQ_OUT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KSQ    = 2'd2;
  localparam logic [HR_W-1:0] MIN_HR_RST = 8'd20;
  localparam logic [OX_W-1:0] MIN_OX_RST = 7'd50;
  localparam logic [K_W-1:0]  KSQ_RST    = 4'd2 * 4'd2;

  // Internal widths derived from the window depth.
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * 255 + 1);
  localparam int SQ_W   = $clog2(WINDOW * 65025 + 1);
  localparam int HSQ_W  = 2 * HR_W;
  localparam int NH_W   = CNT_W + HR_W;
  localparam int NQ_W   = CNT_W + SQ_W;
  localparam int S2_W   = 2 * SUM_W;
  localparam int SPR_W  = (NQ_W > S2_W) ? NQ_W : S2_W;
  localparam int DD_W   = 2 * NH_W;
  localparam int KS_W   = SPR_W + K_W;
  localparam int TST_W  = (DD_W > KS_W) ? DD_W : KS_W;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // item accepted: latch fields, read oldest ring entry
    logic upd;       // update ring, sums, count, write position
    logic mul;       // n*hr, n*Q, S*S
    logic diff;      // |n*hr - S|, spread
    logic sq;        // d*d, k^2*spread
    logic out_load;  // load result register
  } hrod_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sample_ok; // incoming item passes both thresholds
  } hrod_status_t;

endpackage

`default_nettype wire

// ===== design/hrod_ctrl.sv =====
// Sequencer for the outlier detector: accept, update, multiply, compare, deliver.
// Depends on hrod_pkg for the command and status structs.
`default_nettype none

module hrod_ctrl
  import hrod_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire hrod_status_t status,
  output hrod_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MUL,
    ST_DIFF,
    ST_SQ,
    ST_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && s_tvalid;
    cmd.upd      = (state == ST_UPD);
    cmd.mul      = (state == ST_MUL);
    cmd.diff     = (state == ST_DIFF);
    cmd.sq       = (state == ST_SQ);
    cmd.out_load = (state == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            // rejected samples skip straight to delivery
            state <= status.sample_ok ? ST_UPD : ST_FIN;
          end
        end
        ST_UPD:  state <= ST_MUL;
        ST_MUL:  state <= ST_DIFF;
        ST_DIFF: state <= ST_SQ;
        ST_SQ:   state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/hrod_datapath.sv =====
// Datapath: config registers, sample ring memory, running sums and the
// exact-integer z-score test. Depends on hrod_pkg; driven by hrod_ctrl.
`default_nettype none

module hrod_datapath
  import hrod_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [HR_W-1:0]       heart_rate,
  input  wire logic [OX_W-1:0]       spo2,
  input  wire hrod_cmd_t             cmd,
  output hrod_status_t               status,
  output logic                       present,
  output logic                       abnormal,
  output logic [CNT_OUT_W-1:0]       window_count,
  output logic [SUM_OUT_W-1:0]       window_sum,
  output logic [SQ_OUT_W-1:0]        window_sum_squares
);

  logic [HR_W-1:0]  min_hr;
  logic [OX_W-1:0]  min_ox;
  logic [K_W-1:0]   ksq;

  logic [HR_W-1:0]  ring [WINDOW];
  logic [HR_W-1:0]  old_rd;

  logic [POS_W-1:0] wpos;
  logic [CNT_W-1:0] fill;
  logic [SUM_W-1:0] sum;
  logic [SQ_W-1:0]  sumsq;

  logic [HR_W-1:0]  hr_q;
  logic             ok_q;

  logic [NH_W-1:0]  nh;
  logic [NQ_W-1:0]  nq;
  logic [S2_W-1:0]  s2;
  logic [NH_W-1:0]  diff_abs;
  logic [SPR_W-1:0] spread;
  logic [DD_W-1:0]  dd;
  logic [KS_W-1:0]  ks;

  logic             full;
  logic [HR_W-1:0]  old_val;
  logic [HSQ_W-1:0] old_sq;
  logic [HSQ_W-1:0] hr_sq;
  logic [NH_W-1:0]  sum_ext;
  logic [SPR_W-1:0] nq_ext;
  logic [SPR_W-1:0] s2_ext;

  assign status.sample_ok = (heart_rate > min_hr) && (spo2 > min_ox);

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_hr <= MIN_HR_RST;
      min_ox <= MIN_OX_RST;
      ksq    <= KSQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_HR: min_hr <= cfg_data[HR_W-1:0];
        REG_MIN_OX: min_ox <= cfg_data[OX_W-1:0];
        REG_KSQ:    ksq    <= cfg_data[K_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring memory: read oldest on accept, overwrite it on update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      old_rd <= ring[wpos];
    end
    if (cmd.upd) begin
      ring[wpos] <= hr_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hr_q <= heart_rate;
      ok_q <= status.sample_ok;
    end
  end

  assign full    = (fill == CNT_W'(WINDOW));
  assign old_val = full ? old_rd : '0;
  assign old_sq  = HSQ_W'(old_val) * HSQ_W'(old_val);
  assign hr_sq   = HSQ_W'(hr_q) * HSQ_W'(hr_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos  <= '0;
      fill  <= '0;
      sum   <= '0;
      sumsq <= '0;
    end else if (cmd.upd) begin
      sum   <= sum + SUM_W'(hr_q) - SUM_W'(old_val);
      sumsq <= sumsq + SQ_W'(hr_sq) - SQ_W'(old_sq);
      if (!full) begin
        fill <= fill + CNT_W'(1);
      end
      wpos <= (wpos == POS_W'(WINDOW - 1)) ? '0 : wpos + POS_W'(1);
    end
  end

  // Test: (n*hr - S)^2 > k^2 * max(n*Q - S^2, 0)
  assign sum_ext = NH_W'(sum);
  assign nq_ext  = SPR_W'(nq);
  assign s2_ext  = SPR_W'(s2);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      nh <= NH_W'(fill) * NH_W'(hr_q);
      nq <= NQ_W'(fill) * NQ_W'(sumsq);
      s2 <= S2_W'(sum) * S2_W'(sum);
    end
    if (cmd.diff) begin
      diff_abs <= (nh >= sum_ext) ? nh - sum_ext : sum_ext - nh;
      spread   <= (nq_ext > s2_ext) ? nq_ext - s2_ext : '0;
    end
    if (cmd.sq) begin
      dd <= DD_W'(diff_abs) * DD_W'(diff_abs);
      ks <= KS_W'(spread) * KS_W'(ksq);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      present            <= ok_q;
      abnormal           <= ok_q && (TST_W'(dd) > TST_W'(ks));
      window_count       <= CNT_OUT_W'(fill);
      window_sum         <= SUM_OUT_W'(sum);
      window_sum_squares <= SQ_OUT_W'(sumsq);
    end
  end

endmodule

`default_nettype wire

// ===== design/heart_rate_outlier_detector.sv =====
// Heart-rate outlier detector: top level joining controller and datapath.
// Depends on hrod_pkg, hrod_ctrl and hrod_datapath.
//
// Input stream (s_*): one heart-rate / SpO2 item per handshake. A sample whose
// heart rate and SpO2 both exceed their thresholds enters a 50-entry sliding
// window; it is then tested against mean +/- k sigma in exact integers.
// Output stream (m_*): one result item per input item, in order.
// cfg_*: register writes (0 min heart rate, 1 min SpO2, 2 k squared), taken
// at any edge with cfg_we high; write only while no item is in flight.
//
// Flow: a valid sample's result passes through the ring and sum update, three
// parallel multiplies, difference and squaring, then the compare into the
// result register; a rejected sample goes straight to the result register.
// One item is in work at a time and the next can be taken the cycle after the
// result loads, so a new item is not accepted before the previous one's result
// has been loaded by the sequential update/multiply/compare chain.
// The result register lets the next item be accepted while a result still
// waits; if the receiver stalls, the following item parks in its final step
// until the register frees up. Reset empties the window, clears sums and
// restores register defaults; no memory clearing pass is needed.
`default_nettype none

module heart_rate_outlier_detector
  import hrod_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [7:0] heart_rate, [14:8] spo2, [15] zero
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [0] present, [1] abnormal, [7:2] window_count, [21:8] window_sum,
  // [43:22] window_sum_squares, [47:44] zero
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  hrod_cmd_t             cmd;
  hrod_status_t          status;
  logic                  present;
  logic                  abnormal;
  logic [CNT_OUT_W-1:0]  window_count;
  logic [SUM_OUT_W-1:0]  window_sum;
  logic [SQ_OUT_W-1:0]   window_sum_squares;

  hrod_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hrod_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .heart_rate         (s_tdata[HR_W-1:0]),
    .spo2               (s_tdata[HR_W +: OX_W]),
    .cmd                (cmd),
    .status             (status),
    .present            (present),
    .abnormal           (abnormal),
    .window_count       (window_count),
    .window_sum         (window_sum),
    .window_sum_squares (window_sum_squares)
  );

  assign m_tdata = OUT_DATA_W'({window_sum_squares, window_sum, window_count,
                                abnormal, present});

  // An accepted item blocks the input until its result is built.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted back to back");

  // Only a valid sample can be flagged.
  a_abn_present: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && abnormal |-> present)
    else $error("abnormal without present");

  // The window never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(window_count) <= 32'(WINDOW)))
    else $error("window count beyond depth");

  // A result is loaded only when the output slot is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for heart_rate_outlier_detector.
// Depends on hrod_pkg and the RTL top; a scoreboard class predicts every result item
// from the accepted samples and checks the output stream in order.

module tb_top
  import hrod_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic                 present;
    logic                 abnormal;
    logic [CNT_OUT_W-1:0] count;
    logic [SUM_OUT_W-1:0] sum;
    logic [SQ_OUT_W-1:0]  sum_sq;
  } hr_result_t;

  class hr_scoreboard;
    hr_result_t      expected_results[$];
    logic [HR_W-1:0] ring[WINDOW];
    int unsigned     wr_pos, fill, sum, sum_sq;
    int unsigned     min_hr, min_ox, k_sq;
    int              errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_pos = 0; fill = 0; sum = 0; sum_sq = 0;
      min_hr = MIN_HR_RST; min_ox = MIN_OX_RST; k_sq = KSQ_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MIN_HR: min_hr = val & 8'hFF;
        REG_MIN_OX: min_ox = val & 8'h7F;
        REG_KSQ:    k_sq   = val & 8'h0F;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Window update and exact k-sigma test for one accepted sample.
    function void note_sample(logic [HR_W-1:0] hr, logic [OX_W-1:0] ox);
      hr_result_t      r;
      int unsigned     pos, old, h;
      longint unsigned n, s, q, nh, d, nq, s2, spread;
      r.present = 1'b0;
      r.abnormal = 1'b0;
      h = hr;
      if (h > min_hr && int'(ox) > min_ox) begin
        pos = (wr_pos >= WINDOW) ? 0 : wr_pos;
        if (fill >= WINDOW) begin
          old = ring[pos];
          sum -= old;
          sum_sq -= old * old;
        end else begin
          fill++;
        end
        ring[pos] = hr;
        sum += h;
        sum_sq += h * h;
        pos++;
        wr_pos = (pos >= WINDOW) ? 0 : pos;
        n = fill; s = sum; q = sum_sq;
        nh = n * h;
        d = (nh >= s) ? nh - s : s - nh;
        nq = n * q;
        s2 = s * s;
        spread = (nq > s2) ? nq - s2 : 0;
        r.abnormal = (d * d > longint'(k_sq) * spread);
        r.present = 1'b1;
      end
      r.count  = fill[CNT_OUT_W-1:0];
      r.sum    = sum[SUM_OUT_W-1:0];
      r.sum_sq = sum_sq[SQ_OUT_W-1:0];
      expected_results.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      hr_result_t exp_r;
      if (expected_results.size() == 0) begin
        report($sformatf("result item with nothing expected, data %h", data));
      end else begin
        exp_r = expected_results.pop_front();
        if (data[0] !== exp_r.present)
          report($sformatf("present %b, expected %b", data[0], exp_r.present));
        if (data[1] !== exp_r.abnormal)
          report($sformatf("abnormal %b, expected %b", data[1], exp_r.abnormal));
        if (data[7:2] !== exp_r.count)
          report($sformatf("window_count %0d, expected %0d", data[7:2], exp_r.count));
        if (data[21:8] !== exp_r.sum)
          report($sformatf("window_sum %0d, expected %0d", data[21:8], exp_r.sum));
        if (data[43:22] !== exp_r.sum_sq)
          report($sformatf("window_sum_squares %0d, expected %0d",
                           data[43:22], exp_r.sum_sq));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  hr_scoreboard sb = new();

  // 0: no idling, 1: sender idle, 2: receiver stalls, 3: both, lightly
  int idle_mode = 0;
  int rnd_items = 0;
  int cur_min_hr = MIN_HR_RST;
  int cur_min_ox = MIN_OX_RST;

  heart_rate_outlier_detector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function int send_idle_pct();
    return (idle_mode == 1) ? 61 : (idle_mode == 3) ? 15 : 0;
  endfunction

  function int recv_stall_pct();
    return (idle_mode == 2) ? 61 : (idle_mode == 3) ? 15 : 0;
  endfunction

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct());
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge after the item is taken.
  task automatic send_sample(logic [HR_W-1:0] hr, logic [OX_W-1:0] ox);
    while (send_idle_pct() != 0 && $urandom_range(99) < send_idle_pct()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W - IN_BITS){1'b0}}, ox, hr};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(hr, ox);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Raw values go out as given so the masking of wide writes is exercised.
  task automatic apply_config(logic [7:0] hr_min, logic [7:0] ox_min, logic [7:0] ksq);
    write_reg(REG_MIN_HR, hr_min);
    write_reg(REG_MIN_OX, ox_min);
    write_reg(REG_KSQ, ksq);
    cur_min_hr = hr_min;
    cur_min_ox = ox_min & 8'h7F;
  endtask

  // Mostly valid samples around a drifting base, some outliers, some raw noise.
  task automatic run_random(int count);
    int hr, ox, r, base, jitter, lo_hr, lo_ox;
    bit can_pass;
    lo_hr = cur_min_hr + 1;
    lo_ox = cur_min_ox + 1;
    can_pass = (lo_hr <= 255) && (lo_ox <= 127);
    base = 0;
    jitter = 0;
    for (int i = 0; i < count; i++) begin
      idle_mode = (rnd_items / 50) % 4;
      if (i % 40 == 0 && can_pass) begin
        base = $urandom_range(255, lo_hr);
        jitter = $urandom_range(8, 0);
      end
      r = $urandom_range(99);
      if (can_pass && r < 70) begin
        hr = base + int'($urandom_range(2 * jitter)) - jitter;
        if (hr < lo_hr) hr = lo_hr;
        if (hr > 255) hr = 255;
        ox = $urandom_range(127, lo_ox);
      end else if (can_pass && r < 80) begin
        hr = $urandom_range(255, lo_hr);
        ox = $urandom_range(127, lo_ox);
      end else begin
        hr = $urandom_range(255);
        ox = $urandom_range(127);
      end
      send_sample(hr[7:0], ox[6:0]);
      rnd_items++;
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset thresholds: equal samples first (zero spread), then the
    // field extremes and the threshold boundaries.
    idle_mode = 0;
    repeat (4) send_sample(8'd70, 7'd97);
    send_sample(8'd0, 7'd0);
    send_sample(8'd255, 7'd127);
    send_sample(8'd20, 7'd100);
    send_sample(8'd21, 7'd50);
    send_sample(8'd21, 7'd51);
    send_sample(8'd128, 7'd64);
    send_sample(8'd1, 7'd127);
    send_sample(8'd254, 7'd51);
    send_sample(8'd85, 7'd126);
    send_sample(8'd170, 7'd85);
    send_sample(8'd255, 7'd0);
    send_sample(8'd70, 7'd99);
    s_tvalid <= 1'b0;
    drain();

    // Lowest thresholds, k squared of zero; the upper bits must be masked off.
    apply_config(8'd0, 8'h80, 8'hF0);
    run_random(150);
    drain();

    // Highest thresholds: nothing can pass. The unused index must be ignored.
    apply_config(8'd255, 8'd127, 8'd15);
    write_reg(REG_UNUSED, 8'h00);
    run_random(40);
    drain();

    apply_config(8'd60, 8'd90, 8'h19);
    run_random(200);
    drain();

    apply_config(8'd20, 8'd50, 8'd4);
    run_random(200);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hrod_pkg.sv
design/hrod_ctrl.sv
design/hrod_datapath.sv
design/heart_rate_outlier_detector.sv
dv/tb_top.sv
